// ----- hdl/cht_pkg.sv -----
package cht_pkg;

  localparam int MaxBuckets = 64;
  localparam int PoolNodes  = 256;
  localparam int ValueBits  = 64;

  localparam int BktW  = $clog2(MaxBuckets);
  localparam int NodeW = $clog2(PoolNodes);
  localparam int LinkW = NodeW + 1;
  localparam int KeyW  = 31;
  localparam int SizeW = 7;
  localparam int StepW = NodeW + 1;

  localparam logic [LinkW-1:0] NilLink = LinkW'(PoolNodes);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_DISPATCH,
    S_READ,
    S_CHECK,
    S_UNLINK,
    S_FREE,
    S_INS,
    S_DONE
  } state_t;

endpackage

// ----- hdl/cht_if.sv -----
interface cht_req_if;
  import cht_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [KeyW-1:0] key;
  logic [63:0] value;
  modport source (output valid, action, key, value, input ready);
  modport sink (input valid, action, key, value, output ready);
endinterface

interface cht_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [63:0] found_value;
  modport source (output valid, status, found_value, input ready);
  modport sink (input valid, status, found_value, output ready);
endinterface

// ----- hdl/chained_hash_table.sv -----
// channel   dir  payload
// req       in   action, key, value
// rsp       out  status, found_value
// cfg       in   cfg_we, cfg_data (table_size)
// one request at a time: the modulo runs one restoring step a cycle on a
// shared subtractor, then the chain is walked node by node (S_READ, S_CHECK),
// and the FSM returns through S_DONE to S_IDLE before the next request is taken.
// after reset a pass builds the free list in node_link; no request
// is taken meanwhile. a finished result waits in the output register while
// rsp.ready is low; the next request may start but holds in S_DONE until then.
module chained_hash_table import cht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [SizeW-1:0] cfg_data,
  cht_req_if.sink          req,
  cht_rsp_if.source        rsp
);

  // memories
  logic [LinkW-1:0]     bucket_head [MaxBuckets];
  logic [MaxBuckets-1:0] head_ok;
  logic [KeyW-1:0]      node_key  [PoolNodes];
  logic [ValueBits-1:0] node_value[PoolNodes];
  logic [LinkW-1:0]     node_link [PoolNodes];

  state_t state, state_next;
  logic [SizeW-1:0] table_size;
  logic [1:0]       act;
  logic [KeyW-1:0]  key;
  logic [ValueBits-1:0] val;
  logic [SizeW-1:0] div;
  logic [SizeW-1:0] rem;
  logic [4:0]       bitpos;
  logic [BktW-1:0]  bkt;
  logic [LinkW-1:0] cur, prev, free_head;
  logic [StepW-1:0] steps;
  logic [NodeW:0]   init_cnt;
  logic [KeyW-1:0]  rd_key;
  logic [ValueBits-1:0] rd_val;
  logic [LinkW-1:0] rd_link;
  logic [LinkW-1:0] head_rd;
  logic [LinkW-1:0] head_link;
  logic [1:0]       out_status;
  logic [63:0]      out_value;
  logic [1:0]       rsp_status;
  logic [63:0]      rsp_value;
  logic             out_valid;

  // shared restoring step
  logic [SizeW:0] shifted, diff;
  assign shifted = {rem, key[bitpos]};
  assign diff    = shifted - {1'b0, div};

  // head of the current bucket, null when never written
  assign head_link = head_ok[bkt] ? head_rd : NilLink;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:     if (init_cnt == LinkW'(PoolNodes - 1)) state_next = S_IDLE;
      S_IDLE:     if (req.valid) state_next = S_MOD;
      S_MOD:      if (bitpos == 5'd0) state_next = S_HEAD;
      S_HEAD:     state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (act == ACT_INSERT) state_next = S_INS;
        else if (act == ACT_NONE) state_next = S_DONE;
        else if (!head_link[NodeW]) state_next = S_READ;
        else state_next = S_DONE;
      end
      S_READ:     state_next = S_CHECK;
      S_CHECK: begin
        if (rd_key == key) state_next = (act == ACT_DELETE) ? S_UNLINK : S_DONE;
        else if (rd_link[NodeW] || steps == StepW'(PoolNodes - 1)) state_next = S_DONE;
        else state_next = S_READ;
      end
      S_UNLINK:   state_next = S_FREE;
      S_FREE:     state_next = S_DONE;
      S_INS:      state_next = S_DONE;
      S_DONE:     if (!out_valid || rsp.ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready = (state == S_IDLE);
  end
  assign rsp.valid       = out_valid;
  assign rsp.status      = rsp_status;
  assign rsp.found_value = rsp_value;

  // memory reads, registered
  always_ff @(posedge clk) begin
    rd_key  <= node_key[cur[NodeW-1:0]];
    rd_val  <= node_value[cur[NodeW-1:0]];
    rd_link <= node_link[cur[NodeW-1:0]];
  end

  // bucket head read, registered
  always_ff @(posedge clk) begin
    head_rd <= bucket_head[rem[BktW-1:0]];
  end

  // node memory writes
  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      node_link[init_cnt[NodeW-1:0]] <= LinkW'(init_cnt) + LinkW'(1);
    end else if (state == S_INS && !free_head[NodeW]) begin
      node_key[free_head[NodeW-1:0]]   <= key;
      node_value[free_head[NodeW-1:0]] <= val;
      node_link[free_head[NodeW-1:0]]  <= head_link;
    end else if (state == S_UNLINK && !prev[NodeW]) begin
      node_link[prev[NodeW-1:0]] <= rd_link;
    end else if (state == S_FREE) begin
      node_link[cur[NodeW-1:0]] <= free_head;
    end
  end

  // bucket heads
  always_ff @(posedge clk) begin
    if (state == S_INS && !free_head[NodeW]) bucket_head[bkt] <= free_head;
    else if (state == S_UNLINK && prev[NodeW]) bucket_head[bkt] <= rd_link;
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      table_size <= SizeW'(MaxBuckets);
      head_ok    <= '0;
      init_cnt   <= '0;
      free_head  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) table_size <= cfg_data;
      // result register handshake
      if (state == S_DONE && (!out_valid || rsp.ready)) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_INIT: init_cnt <= init_cnt + 1'b1;
        S_IDLE: if (req.valid) begin
          act    <= req.action;
          key    <= req.key;
          val    <= req.value[ValueBits-1:0];
          rem    <= '0;
          bitpos <= 5'(KeyW - 1);
          if (table_size == '0) div <= SizeW'(1);
          else if (table_size > SizeW'(MaxBuckets)) div <= SizeW'(MaxBuckets);
          else div <= table_size;
        end
        S_MOD: begin
          rem    <= diff[SizeW] ? shifted[SizeW-1:0] : diff[SizeW-1:0];
          bitpos <= bitpos - 5'd1;
        end
        S_HEAD: begin
          bkt   <= rem[BktW-1:0];
          prev  <= NilLink;
          steps <= '0;
          // insert: fetch free node link ahead of S_INS
          if (act == ACT_INSERT) cur <= free_head;
        end
        S_DISPATCH: begin
          out_value <= '0;
          if (act != ACT_INSERT) cur <= head_link;
          // empty chain on delete or search
          if ((act == ACT_DELETE || act == ACT_SEARCH) && head_link[NodeW])
            out_status <= ST_NOTFOUND;
          else
            out_status <= ST_OK;
        end
        S_READ: ;
        S_CHECK: begin
          if (rd_key == key) begin
            if (act == ACT_SEARCH) out_value <= 64'(rd_val);
          end else begin
            prev  <= cur;
            cur   <= rd_link;
            steps <= steps + 1'b1;
            if (rd_link[NodeW] || steps == StepW'(PoolNodes - 1)) out_status <= ST_NOTFOUND;
          end
        end
        S_UNLINK: if (prev[NodeW]) head_ok[bkt] <= 1'b1;
        S_FREE: free_head <= cur;
        S_INS: begin
          if (free_head[NodeW]) begin
            out_status <= ST_FULL;
          end else begin
            free_head    <= rd_link;
            head_ok[bkt] <= 1'b1;
          end
        end
        S_DONE: if (!out_valid || rsp.ready) begin
          rsp_status <= out_status;
          rsp_value  <= out_value;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("ready while busy");
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS && free_head[NodeW]) |=> (out_status == ST_FULL))
    else $error("full status missing");
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |-> (div != '0 && div <= SizeW'(MaxBuckets)))
    else $error("divisor out of range");
`endif

endmodule

// ----- test/cht_checker.sv -----
module cht_checker import cht_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  cht_req_if         req,
  cht_rsp_if         rsp,
  output int         fail_count,
  output int         pending,
  output int         rsp_seen
);

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_value;
  } reply_t;

  logic [LinkW-1:0] head_tbl [MaxBuckets];
  logic [KeyW-1:0]  key_tbl  [PoolNodes];
  logic [63:0]      val_tbl  [PoolNodes];
  logic [LinkW-1:0] link_tbl [PoolNodes];
  logic [LinkW-1:0] free_ptr;
  logic [6:0]       size_reg;
  reply_t           reply_q [$];

  assign pending = reply_q.size();

  // prediction of one request, updates the shadow table
  function automatic reply_t hash_op(logic [1:0] act, logic [KeyW-1:0] k,
                                     logic [63:0] v);
    reply_t r;
    int n;
    int b;
    int cur;
    int prv;
    int steps;
    r = '0;
    n = (size_reg == 0) ? 1 : (size_reg > MaxBuckets ? MaxBuckets : int'(size_reg));
    b = int'(k) % n;
    if (act == ACT_INSERT) begin
      if (free_ptr >= PoolNodes) begin
        r.status = ST_FULL;
      end else begin
        cur = int'(free_ptr);
        free_ptr = link_tbl[cur];
        key_tbl[cur] = k;
        val_tbl[cur] = v;
        link_tbl[cur] = head_tbl[b];
        head_tbl[b] = LinkW'(cur);
      end
    end else if (act == ACT_DELETE || act == ACT_SEARCH) begin
      prv = PoolNodes;
      cur = int'(head_tbl[b]);
      steps = 0;
      while (cur < PoolNodes && key_tbl[cur] != k && steps < PoolNodes) begin
        prv = cur;
        cur = int'(link_tbl[cur]);
        steps++;
      end
      if (cur >= PoolNodes || key_tbl[cur] != k) begin
        r.status = ST_NOTFOUND;
      end else if (act == ACT_SEARCH) begin
        r.found_value = val_tbl[cur];
      end else begin
        if (prv < PoolNodes) link_tbl[prv] = link_tbl[cur];
        else head_tbl[b] = link_tbl[cur];
        link_tbl[cur] = free_ptr;
        free_ptr = LinkW'(cur);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  // watch the channels at each edge
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < MaxBuckets; i++) head_tbl[i] = NilLink;
      for (int i = 0; i < PoolNodes; i++) link_tbl[i] = LinkW'(i + 1);
      free_ptr = '0;
      size_reg = 7'd64;
      reply_q.delete();
      fail_count = 0;
      rsp_seen = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp_seen++;
        if (reply_q.size() == 0) begin
          report_mismatch("unexpected beat", 64'(rsp.status), 64'd0);
        end else begin
          want = reply_q.pop_front();
          if (rsp.status != want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.found_value != want.found_value)
            report_mismatch("found_value", rsp.found_value, want.found_value);
        end
      end
      if (req.valid && req.ready)
        reply_q.push_back(hash_op(req.action, req.key, req.value));
      if (cfg_we) size_reg = cfg_data;
    end
  end

endmodule

// ----- test/tb_chained_hash_table.sv -----
module tb_chained_hash_table;
  import cht_pkg::*;

  logic       clk = 0;
  logic       rst = 1;
  logic       cfg_we = 0;
  logic [6:0] cfg_data = 0;
  int         fail_count;
  int         pending;
  int         rsp_seen;
  int         sent = 0;
  bit         calm = 0;
  logic [KeyW-1:0] used_keys [$];

  cht_req_if req ();
  cht_rsp_if rsp ();

  chained_hash_table dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  cht_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req), .rsp(rsp), .fail_count(fail_count), .pending(pending),
    .rsp_seen(rsp_seen)
  );

  always #5 clk = ~clk;

  // receiver stalls in bursts
  initial begin
    int gap;
    rsp.ready = 0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 5);
        rsp.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1;
      @(posedge clk);
    end
  end

  task automatic send_beat(logic [1:0] act, logic [KeyW-1:0] k, logic [63:0] v);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1;
    req.action <= act;
    req.key <= k;
    req.value <= v;
    do @(posedge clk); while (!req.ready);
    sent++;
  endtask

  task automatic drain();
    req.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_size(logic [6:0] s);
    drain();
    cfg_we <= 1;
    cfg_data <= s;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    return ($urandom_range(0, 1) != 0) ? KeyW'($urandom_range(0, 200)) : KeyW'($urandom);
  endfunction

  function automatic logic [1:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return ACT_INSERT;
    if (r < 65) return ACT_DELETE;
    if (r < 97) return ACT_SEARCH;
    return ACT_NONE;
  endfunction

  // stimulus
  initial begin
    logic [KeyW-1:0] k;
    logic [1:0] a;
    logic [6:0] sizes [6];
    req.valid = 0;
    req.action = 0;
    req.key = 0;
    req.value = 0;
    sizes = '{7'd1, 7'd0, 7'd127, 7'd7, 7'd64, 7'd3};
    repeat (4) @(posedge clk);
    rst <= 0;
    // directed: empty table, extremes, duplicates, ignored action
    send_beat(ACT_SEARCH, 0, 0);
    send_beat(ACT_DELETE, 31'h7fffffff, 0);
    send_beat(ACT_INSERT, 31'h7fffffff, 64'hffffffffffffffff);
    send_beat(ACT_INSERT, 0, 64'h0);
    send_beat(ACT_INSERT, 64, 64'h5555aaaa5555aaaa);
    send_beat(ACT_INSERT, 64, 64'haaaa5555aaaa5555);
    send_beat(ACT_SEARCH, 64, 0);
    send_beat(ACT_SEARCH, 31'h7fffffff, 0);
    send_beat(ACT_DELETE, 0, 0);
    send_beat(ACT_SEARCH, 0, 0);
    send_beat(ACT_DELETE, 64, 0);
    send_beat(ACT_SEARCH, 64, 0);
    send_beat(ACT_NONE, 5, 64'h1234);
    send_beat(ACT_SEARCH, 128, 0);
    // stale hash after size change
    set_size(7'd5);
    send_beat(ACT_SEARCH, 31'h7fffffff, 0);
    set_size(7'd64);
    // fill the pool to overflow
    for (int i = 0; i < 260; i++) send_beat(ACT_INSERT, KeyW'(i * 3), {$urandom, $urandom});
    send_beat(ACT_INSERT, 9, 64'h1);
    for (int i = 0; i < 260; i++) send_beat(ACT_DELETE, KeyW'(i * 3), 0);
    // random phases over several sizes
    for (int p = 0; p < 6; p++) begin
      set_size(sizes[p]);
      for (int i = 0; i < 80; i++) begin
        if (p == 5 && i == 40) calm = 1;
        a = pick_action();
        k = pick_key();
        if (a == ACT_INSERT) used_keys.push_back(k);
        if (used_keys.size() > 64) void'(used_keys.pop_front());
        send_beat(a, k, {$urandom, $urandom});
      end
    end
    drain();
    $display("sent %0d requests, checked %0d replies over six table sizes", sent, rsp_seen);
    $display("covered pool overflow, duplicate keys, ignored action and stale hashing");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
